[rtl/assert_macros.svh]
// Assertion macros shared by the signal pack/unpack RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define CSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define CSP_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/csp_pkg.sv]
// Shared constants, types and a helper function for the signal pack/unpack block.
package csp_pkg;

    localparam int CSP_FRAME_BYTES = 8;
    localparam int CSP_BYTE_BITS   = 8;
    localparam int CSP_WORD_W      = 64;
    localparam int CSP_WORD_BYTES  = CSP_WORD_W / CSP_BYTE_BITS;
    localparam int CSP_START_W     = 6;
    localparam int CSP_LEN_W       = 7;
    localparam int CSP_SHIFT_W     = 7;
    localparam int CSP_POS_W       = 6;
    localparam int CSP_SPAN_W      = 8;
    localparam int CSP_IDX_W       = 3;
    localparam int CSP_CFG_DATA_W  = 7;

    localparam logic [CSP_LEN_W-1:0]   CSP_MAX_LEN       = CSP_LEN_W'(CSP_WORD_W);
    localparam logic [CSP_START_W-1:0] CSP_BIT_IN_BYTE   = CSP_START_W'(CSP_BYTE_BITS - 1);

    // Configuration register indexes
    localparam logic [CSP_IDX_W-1:0] CSP_REG_START_BIT  = 3'd0;
    localparam logic [CSP_IDX_W-1:0] CSP_REG_BIT_LENGTH = 3'd1;
    localparam logic [CSP_IDX_W-1:0] CSP_REG_MOTOROLA   = 3'd2;
    localparam logic [CSP_IDX_W-1:0] CSP_REG_SIGNED     = 3'd3;

    // Function codes
    localparam logic CSP_FUNC_ENCODE = 1'b1;

    typedef struct packed {
        logic [CSP_START_W-1:0] start_bit;
        logic [CSP_LEN_W-1:0]   bit_length;
        logic                   motorola_order;
        logic                   signed_value;
    } csp_cfg_t;

    typedef struct packed {
        logic                   encode;
        logic                   moto;
        logic [CSP_WORD_W-1:0]  word;
        logic [CSP_WORD_W-1:0]  src;
        logic [CSP_WORD_W-1:0]  raw;
        logic [CSP_WORD_W-1:0]  len_mask;
        logic [CSP_WORD_W-1:0]  valid_mask;
        logic                   shift_left;
        logic [CSP_SHIFT_W-1:0] shift_amt;
        logic                   sign_en;
        logic [CSP_POS_W-1:0]   sign_pos;
        logic                   outside;
    } csp_s1_t;

    typedef struct packed {
        logic                   encode;
        logic                   moto;
        logic [CSP_WORD_W-1:0]  word;
        logic [CSP_WORD_W-1:0]  dec;
        logic [CSP_WORD_W-1:0]  ins_mask;
        logic [CSP_WORD_W-1:0]  ins_data;
        logic [CSP_WORD_W-1:0]  len_mask;
        logic                   sign_en;
        logic [CSP_POS_W-1:0]   sign_pos;
        logic                   outside;
    } csp_s2_t;

    // Reverse the byte order of a payload word.
    function automatic logic [CSP_WORD_W-1:0] csp_bswap(input logic [CSP_WORD_W-1:0] w);
        logic [CSP_WORD_W-1:0] r;
        r = '0;
        for (int k = 0; k < CSP_WORD_BYTES; k++)
        begin
            r[k*CSP_BYTE_BITS +: CSP_BYTE_BITS] =
                w[(CSP_WORD_BYTES-1-k)*CSP_BYTE_BITS +: CSP_BYTE_BITS];
        end
        return r;
    endfunction

endpackage

[rtl/csp_if.sv]
// Valid/ready channel interfaces for the command and result transactions.
interface csp_cmd_if;
    logic                            valid;
    logic                            ready;
    logic                            func;
    logic [csp_pkg::CSP_WORD_W-1:0]  frame_in;
    logic [csp_pkg::CSP_WORD_W-1:0]  raw_value;

    modport source (output valid, output func, output frame_in, output raw_value, input ready);
    modport sink   (input valid, input func, input frame_in, input raw_value, output ready);
endinterface

interface csp_res_if;
    logic                            valid;
    logic                            ready;
    logic [csp_pkg::CSP_WORD_W-1:0]  decoded_value;
    logic [csp_pkg::CSP_WORD_W-1:0]  frame_out;
    logic                            outside_frame;

    modport source (output valid, output decoded_value, output frame_out,
                    output outside_frame, input ready);
    modport sink   (input valid, input decoded_value, input frame_out,
                    input outside_frame, output ready);
endinterface

[rtl/csp_cfg_regs.sv]
// Configuration register file for the signal layout.
module csp_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [csp_pkg::CSP_IDX_W-1:0]       cfg_index,
    input  logic [csp_pkg::CSP_CFG_DATA_W-1:0]  cfg_data,
    output csp_pkg::csp_cfg_t                   cfg
);
    import csp_pkg::*;

    csp_cfg_t cfg_reg;
    csp_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CSP_REG_START_BIT:  cfg_next.start_bit      = cfg_data[CSP_START_W-1:0];
                CSP_REG_BIT_LENGTH: cfg_next.bit_length     = cfg_data[CSP_LEN_W-1:0];
                CSP_REG_MOTOROLA:   cfg_next.motorola_order = cfg_data[0];
                CSP_REG_SIGNED:     cfg_next.signed_value   = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_bit      <= '0;
            cfg_reg.bit_length     <= '0;
            cfg_reg.motorola_order <= 1'b1;
            cfg_reg.signed_value   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/csp_prep.sv]
// First stage: map the payload into a linear working order and work out shifts and masks.
module csp_prep #(
    parameter int FRAME_BYTES = csp_pkg::CSP_FRAME_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  csp_pkg::csp_cfg_t cfg,
    csp_cmd_if.sink           cmd,
    output logic              s1_valid,
    input  logic              s1_ready,
    output csp_pkg::csp_s1_t  s1_data
);
    import csp_pkg::*;

    localparam int FRAME_BITS = FRAME_BYTES * CSP_BYTE_BITS;
    localparam logic [CSP_WORD_W-1:0] VALID_MASK =
        (FRAME_BITS >= CSP_WORD_W) ? {CSP_WORD_W{1'b1}}
                                   : ((CSP_WORD_W'(1) << FRAME_BITS) - CSP_WORD_W'(1));
    localparam logic [CSP_SPAN_W-1:0] FRAME_SPAN = CSP_SPAN_W'(FRAME_BITS);
    localparam logic [CSP_SPAN_W-1:0] WORD_SPAN  = CSP_SPAN_W'(CSP_WORD_W);

    logic                   s1_valid_reg;
    csp_s1_t                s1_data_reg;
    csp_s1_t                s1_data_next;
    logic [CSP_LEN_W-1:0]   len;
    logic [CSP_START_W-1:0] lsb_pos;
    logic [CSP_SPAN_W-1:0]  span;
    logic                   load;

    always_comb
    begin
        len     = (cfg.bit_length > CSP_MAX_LEN) ? CSP_MAX_LEN : cfg.bit_length;
        // Motorola bit order runs upward once each byte is mirrored
        lsb_pos = cfg.motorola_order ? (cfg.start_bit ^ CSP_BIT_IN_BYTE) : cfg.start_bit;
        span    = CSP_SPAN_W'(lsb_pos) + CSP_SPAN_W'(len);

        s1_data_next.encode     = (cmd.func == CSP_FUNC_ENCODE);
        s1_data_next.moto       = cfg.motorola_order;
        s1_data_next.word       = cfg.motorola_order ? csp_bswap(cmd.frame_in) : cmd.frame_in;
        s1_data_next.valid_mask = cfg.motorola_order ? csp_bswap(VALID_MASK) : VALID_MASK;
        s1_data_next.src        = s1_data_next.word & s1_data_next.valid_mask;
        s1_data_next.raw        = cmd.raw_value;
        s1_data_next.len_mask   = ~({CSP_WORD_W{1'b1}} << len);
        s1_data_next.outside    = (len != '0) && (span > FRAME_SPAN);
        s1_data_next.sign_en    = cfg.signed_value && (len != '0) && (len != CSP_MAX_LEN);
        s1_data_next.sign_pos   = CSP_POS_W'(len - CSP_LEN_W'(1));

        if (!cfg.motorola_order)
        begin
            s1_data_next.shift_left = 1'b0;
            s1_data_next.shift_amt  = CSP_SHIFT_W'(lsb_pos);
        end
        else if (span <= WORD_SPAN)
        begin
            s1_data_next.shift_left = 1'b0;
            s1_data_next.shift_amt  = CSP_SHIFT_W'(WORD_SPAN - span);
        end
        else
        begin
            s1_data_next.shift_left = 1'b1;
            s1_data_next.shift_amt  = CSP_SHIFT_W'(span - WORD_SPAN);
        end
    end

    assign cmd.ready = !s1_valid_reg || s1_ready;
    assign load      = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_data_reg <= s1_data_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_data  = s1_data_reg;

endmodule

[rtl/csp_shift.sv]
// Second stage: barrel-shift the payload for extraction and the value and mask for insertion.
module csp_shift (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s1_valid,
    output logic             s1_ready,
    input  csp_pkg::csp_s1_t s1_data,
    output logic             s2_valid,
    input  logic             s2_ready,
    output csp_pkg::csp_s2_t s2_data
);
    import csp_pkg::*;

    logic    s2_valid_reg;
    csp_s2_t s2_data_reg;
    csp_s2_t s2_data_next;
    logic    load;

    always_comb
    begin
        s2_data_next.encode   = s1_data.encode;
        s2_data_next.moto     = s1_data.moto;
        s2_data_next.word     = s1_data.word;
        s2_data_next.len_mask = s1_data.len_mask;
        s2_data_next.sign_en  = s1_data.sign_en;
        s2_data_next.sign_pos = s1_data.sign_pos;
        s2_data_next.outside  = s1_data.outside;
        if (s1_data.shift_left)
        begin
            s2_data_next.dec      = s1_data.src << s1_data.shift_amt;
            s2_data_next.ins_mask = (s1_data.len_mask >> s1_data.shift_amt) & s1_data.valid_mask;
            s2_data_next.ins_data = s1_data.raw >> s1_data.shift_amt;
        end
        else
        begin
            s2_data_next.dec      = s1_data.src >> s1_data.shift_amt;
            s2_data_next.ins_mask = (s1_data.len_mask << s1_data.shift_amt) & s1_data.valid_mask;
            s2_data_next.ins_data = s1_data.raw << s1_data.shift_amt;
        end
    end

    assign s1_ready = !s2_valid_reg || s2_ready;
    assign load     = s1_valid && s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s2_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_data  = s2_data_reg;

endmodule

[rtl/csp_merge.sv]
// Third stage: mask and sign-extend the extracted value, merge inserted bits, hold the result.
module csp_merge (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s2_valid,
    output logic             s2_ready,
    input  csp_pkg::csp_s2_t s2_data,
    csp_res_if.source        res
);
    import csp_pkg::*;

    logic                  res_valid_reg;
    logic [CSP_WORD_W-1:0] decoded_reg;
    logic [CSP_WORD_W-1:0] frame_reg;
    logic                  outside_reg;
    logic [CSP_WORD_W-1:0] decoded_next;
    logic [CSP_WORD_W-1:0] frame_next;
    logic [CSP_WORD_W-1:0] value;
    logic [CSP_WORD_W-1:0] merged;
    logic                  load;

    always_comb
    begin
        value = s2_data.dec & s2_data.len_mask;
        if (s2_data.sign_en && value[s2_data.sign_pos])
        begin
            value = value | ~s2_data.len_mask;
        end
        merged = s2_data.encode
               ? ((s2_data.word & ~s2_data.ins_mask) | (s2_data.ins_data & s2_data.ins_mask))
               : s2_data.word;
        // Undo the byte mirror of the working order
        frame_next   = s2_data.moto ? csp_bswap(merged) : merged;
        decoded_next = s2_data.encode ? '0 : value;
    end

    assign s2_ready = !res_valid_reg || res.ready;
    assign load     = s2_valid && s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            res_valid_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            decoded_reg <= decoded_next;
            frame_reg   <= frame_next;
            outside_reg <= s2_data.outside;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.decoded_value = decoded_reg;
    assign res.frame_out     = frame_reg;
    assign res.outside_frame = outside_reg;

endmodule

[rtl/can_signal_pack_unpack_top.sv]
// Top level of the CAN signal pack/unpack pipeline.
//
//  Channel   Direction  Handshake              Content
//  cmd       in         cmd.valid/cmd.ready    func, frame_in, raw_value
//  res       out        res.valid/res.ready    decoded_value, frame_out, outside_frame
//  cfg       in         cfg_we                 cfg_index, cfg_data (no read-back)
//
//  A command passes through three register stages to the result: layout prep, barrel
//  shift, merge. One transaction enters every cycle unless a stalled result fills them all.
//  Reset clears the stage valid bits and loads the layout registers with their defaults
//  (start 0, length 0, Motorola order, unsigned); no clearing pass is needed.
//  A stalled result holds every stage that is full; empty stages still fill, so no
//  transaction is lost or repeated.

`include "assert_macros.svh"

module can_signal_pack_unpack_top #(
    parameter int FRAME_BYTES = csp_pkg::CSP_FRAME_BYTES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [csp_pkg::CSP_IDX_W-1:0]       cfg_index,
    input  logic [csp_pkg::CSP_CFG_DATA_W-1:0]  cfg_data,
    csp_cmd_if.sink                             cmd,
    csp_res_if.source                           res
);
    import csp_pkg::*;

    csp_cfg_t cfg;

    // Stage 1 to stage 2 transaction
    logic     s1_valid;
    logic     s1_ready;
    csp_s1_t  s1_data;

    // Stage 2 to stage 3 transaction
    logic     s2_valid;
    logic     s2_ready;
    csp_s2_t  s2_data;

    // Layout registers; the user must write them only while the pipeline is empty, the block does not enforce it
    csp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Mirror Motorola bytes, clamp the length, derive shift direction, amount and masks
    csp_prep #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1_data  (s1_data)
    );

    // Align the signal field with bit zero, or the raw value with the field
    csp_shift u_shift (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1_data  (s1_data),
        .s2_valid (s2_valid),
        .s2_ready (s2_ready),
        .s2_data  (s2_data)
    );

    // Finish the value, write the field into the payload and hold the result
    csp_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .s2_valid (s2_valid),
        .s2_ready (s2_ready),
        .s2_data  (s2_data),
        .res      (res)
    );

    // Back-pressure reaches the command side only when every stage is full
    `CSP_ASSERT(a_full_stall, !cmd.ready |-> (s1_valid && s2_valid && res.valid && !res.ready), "command stalled with an empty stage")
    // An accepted command occupies stage 1 on the next cycle
    `CSP_ASSERT_NEXT(a_accept_fill, cmd.valid && cmd.ready, s1_valid, "accepted command not captured")
    // A disabled signal never reports bits outside the payload
    `CSP_ASSERT(a_zero_len_inside, (res.valid && (cfg.bit_length == '0)) |-> !res.outside_frame, "outside flag with zero length")

endmodule
